// ===== hw/rtl/nfa_wa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_wa_pkg
// Shared types and constants for the nfa word acceptor.
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_wa_pkg;

	localparam int STATE_IDX_W = 4;
	localparam int SYMBOL_W    = 8;
	localparam int SET_W       = 16;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_FEED = 2'd1,
		ACT_END  = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]             action;
		logic [STATE_IDX_W-1:0] from_state;
		logic [SYMBOL_W-1:0]    symbol;
		logic [STATE_IDX_W-1:0] to_state;
	} word_t;

	typedef struct packed {
		logic             accepted;
		logic [SET_W-1:0] final_set;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} fsm_t;

	localparam logic REG_START = 1'b0;
	localparam logic REG_FINAL = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/nfa_word_acceptor.sv =====
// ----------------------------------------------------------------------------
// nfa_word_acceptor
// State-set simulation of a nondeterministic automaton, one symbol per word.
// ----------------------------------------------------------------------------
// Input words arrive on word_valid/word_ready, results leave on
// result_valid/result_ready. A load or feed word first reads every
// successor bank at the symbol address, then writes back the loaded row
// or folds the rows into the active set. The next word is accepted in the
// cycle after that. An end word places its result in the output register,
// visible the next cycle.
// A result waiting on a stalled receiver blocks only further end words;
// load and feed words keep flowing. After reset the table is cleared one
// symbol address per cycle, and no word is accepted until the clear ends;
// APB writes are taken at any time. Reset sets start_state and final_mask
// to zero and the active set to state zero.
// Writing start_state reloads the active set with that state.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_word_acceptor #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                word_valid,
	output      logic                word_ready,
	input  wire nfa_wa_pkg::word_t   word,
	output      logic                result_valid,
	input  wire logic                result_ready,
	output      nfa_wa_pkg::result_t result,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready
);

	import nfa_wa_pkg::*;

	localparam int STATE_AW = $clog2(NUM_STATES);
	localparam int SYM_AW   = $clog2(NUM_SYMBOLS);
	localparam logic [6:0] NUM_STATES_L  = 7'(NUM_STATES);
	localparam logic [8:0] NUM_SYMBOLS_L = 9'(NUM_SYMBOLS);
	localparam logic [SYM_AW-1:0] LAST_ADDR = SYM_AW'(NUM_SYMBOLS - 1);

	fsm_t                    state_q, state_nxt;
	logic [SYM_AW-1:0]       clr_q;
	logic [STATE_IDX_W-1:0]  start_q;
	logic [SET_W-1:0]        final_q;
	logic [NUM_STATES-1:0]   active_q;
	word_t                   op_q;
	logic                    result_valid_q;
	result_t                 result_q;

	logic                    cfg_wr;
	logic                    accept;
	logic                    word_is_end;
	logic                    out_free;
	logic [8:0]              word_sym_ext;
	logic [8:0]              op_sym_ext;
	logic [6:0]              op_from_ext;
	logic [6:0]              op_to_ext;
	logic                    op_ok;
	logic                    op_sym_ok;
	logic [NUM_STATES-1:0]   start_mask;
	logic [NUM_STATES-1:0]   cfg_start_mask;
	logic [NUM_STATES-1:0]   feed_set;
	logic [NUM_STATES+SET_W-1:0] fm_wide;
	logic [NUM_STATES+SET_W-1:0] act_wide;

	logic                                  rd_en;
	logic [SYM_AW-1:0]                     rd_addr;
	logic [NUM_STATES-1:0][NUM_STATES-1:0] rd_data;
	logic                                  wr_en;
	logic                                  wr_all;
	logic [STATE_AW-1:0]                   wr_bank;
	logic [SYM_AW-1:0]                     wr_addr;
	logic [NUM_STATES-1:0]                 wr_data;

	nfa_wa_table #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_all  (wr_all),
		.wr_bank (wr_bank),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign cfg_wr         = psel && penable && pwrite;
	assign pready         = 1'b1;
	assign prdata         = (paddr[2] == REG_FINAL) ? {16'b0, final_q} : {28'b0, start_q};

	assign word_is_end    = (word.action == ACT_END);
	assign out_free       = !result_valid_q || result_ready;
	assign accept         = word_valid && word_ready;
	assign word_sym_ext   = {1'b0, word.symbol};

	assign op_sym_ext     = {1'b0, op_q.symbol};
	assign op_from_ext    = {3'b0, op_q.from_state};
	assign op_to_ext      = {3'b0, op_q.to_state};
	assign op_sym_ok      = op_sym_ext < NUM_SYMBOLS_L;
	assign op_ok          = op_sym_ok && (op_from_ext < NUM_STATES_L) &&
	                        (op_to_ext < NUM_STATES_L);

	// shifts past the top give an empty set for out-of-range states
	assign start_mask     = NUM_STATES'(1) << start_q;
	assign cfg_start_mask = NUM_STATES'(1) << pwdata[STATE_IDX_W-1:0];

	assign fm_wide        = {{NUM_STATES{1'b0}}, final_q};
	assign act_wide       = {{SET_W{1'b0}}, active_q};

	always_comb begin
		feed_set = '0;
		for (int s = 0; s < NUM_STATES; s++) begin
			if (active_q[s]) begin
				feed_set = feed_set | rd_data[s];
			end
		end
		if (!op_sym_ok) begin
			feed_set = '0;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && (word.action == ACT_LOAD || word.action == ACT_FEED)) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		word_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = word_sym_ext[SYM_AW-1:0];
		wr_en      = 1'b0;
		wr_all     = 1'b0;
		wr_bank    = op_from_ext[STATE_AW-1:0];
		wr_addr    = op_sym_ext[SYM_AW-1:0];
		wr_data    = rd_data[op_from_ext[STATE_AW-1:0]] | (NUM_STATES'(1) << op_q.to_state);
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_all  = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				word_ready = !word_is_end || out_free;
				rd_en      = word_valid;
			end
			ST_EXEC: begin
				wr_en = (op_q.action == ACT_LOAD) && op_ok;
			end
			default: begin
				word_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SYM_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			final_q  <= '0;
			active_q <= NUM_STATES'(1);
		end else begin
			if (cfg_wr && paddr[2] == REG_FINAL) begin
				final_q <= pwdata[SET_W-1:0];
			end
			if (cfg_wr && paddr[2] == REG_START) begin
				start_q  <= pwdata[STATE_IDX_W-1:0];
				active_q <= cfg_start_mask;
			end else if (accept && word_is_end) begin
				active_q <= start_mask;
			end else if (state_q == ST_EXEC && op_q.action == ACT_FEED) begin
				active_q <= feed_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && word_is_end) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && word_is_end) begin
			result_q.accepted  <= |(active_q & fm_wide[NUM_STATES-1:0]);
			result_q.final_set <= act_wide[SET_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nfa_wa_table.sv =====
// ----------------------------------------------------------------------------
// nfa_wa_table
// Banked successor table: one bank per source state, addressed by symbol.
// All banks are read together; one bank, or all banks, written per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_wa_table #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 256
) (
	input  wire logic                                          clk,
	input  wire logic                                          rd_en,
	input  wire logic [$clog2(NUM_SYMBOLS)-1:0]                rd_addr,
	output      logic [NUM_STATES-1:0][NUM_STATES-1:0]         rd_data,
	input  wire logic                                          wr_en,
	input  wire logic                                          wr_all,
	input  wire logic [$clog2(NUM_STATES)-1:0]                 wr_bank,
	input  wire logic [$clog2(NUM_SYMBOLS)-1:0]                wr_addr,
	input  wire logic [NUM_STATES-1:0]                         wr_data
);

	localparam int STATE_AW = $clog2(NUM_STATES);

	for (genvar b = 0; b < NUM_STATES; b++) begin : g_bank
		logic [NUM_STATES-1:0] mem [NUM_SYMBOLS];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_all || wr_bank == STATE_AW'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_data[b] <= mem[rd_addr];
			end
		end
	end

endmodule

`default_nettype wire
